>>> rtl/bsd_pkg.sv
// ----------------------------------------------------------------------------
// bsd_pkg: shared definitions for the box signed distance block
// Register indexes, register reset values and the flag groups that travel
// with each beat through the pipeline.
// ----------------------------------------------------------------------------
package bsd_pkg;

    localparam int REG_WIDTH       = 31;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCENE_SIZE_X = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCENE_SIZE_Y = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCENE_SIZE_Z = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CUBE_SIZE    = 3'd3;

    localparam logic [REG_WIDTH-1:0] SCENE_SIZE_RESET = 31'd4194304;
    localparam logic [REG_WIDTH-1:0] CUBE_SIZE_RESET  = 31'd2097152;

    typedef struct packed {
        logic over;
        logic pos;
    } bsd_axis_flags_t;

    typedef struct packed {
        logic sat;
        logic any_pos;
    } bsd_flags_t;

endpackage

>>> rtl/bsd_axis.sv
// ----------------------------------------------------------------------------
// bsd_axis: per-axis offset and square
// Forms twice the face offset q of one coordinate in half-LSB units and its
// square from three half-width partial products, over five register stages.
// ----------------------------------------------------------------------------
module bsd_axis #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  advance,
    input  logic signed [COORD_WIDTH-1:0]         point,
    input  logic [bsd_pkg::REG_WIDTH-1:0]         scene_size,
    input  logic [bsd_pkg::REG_WIDTH-1:0]         cube_size,
    output logic [2*COORD_WIDTH-1:0]              square,
    output logic signed [((COORD_WIDTH+1 > bsd_pkg::REG_WIDTH+1) ?
                          COORD_WIDTH+1 : bsd_pkg::REG_WIDTH+1) + 1:0] offset,
    output bsd_pkg::bsd_axis_flags_t              flags
);

    localparam int W     = COORD_WIDTH;
    localparam int REG_W = bsd_pkg::REG_WIDTH;
    localparam int DW    = ((W + 1 > REG_W + 1) ? W + 1 : REG_W + 1) + 1;
    localparam int QW    = DW + 1;
    localparam int H     = (W + 1) / 2;
    localparam int HW    = W - H;
    localparam int SQW   = 2 * W;

    logic signed [DW-1:0]      d_reg;
    logic [DW-1:0]             ad_reg;
    logic signed [QW-1:0]      q_reg;
    logic signed [QW-1:0]      q4_reg;
    logic signed [QW-1:0]      q5_reg;
    logic [2*HW-1:0]           hh_reg;
    logic [W-1:0]              hl_reg;
    logic [2*H-1:0]            ll_reg;
    logic [SQW-1:0]            square_reg;
    bsd_pkg::bsd_axis_flags_t  flags4_reg;
    bsd_pkg::bsd_axis_flags_t  flags5_reg;

    logic                      pos;
    logic                      over;
    logic [W-1:0]              qp;
    logic [HW-1:0]             hi;
    logic [H-1:0]              lo;

    always_comb
    begin
        pos  = !q_reg[QW-1] && (q_reg != '0);
        over = pos && (q_reg[QW-2:W] != '0);
        qp   = (pos && !over) ? q_reg[W-1:0] : '0;
        hi   = qp[W-1:H];
        lo   = qp[H-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d_reg      <= {{(DW-W-1){point[W-1]}}, point, 1'b0}
                          - {{(DW-REG_W){1'b0}}, scene_size};
            ad_reg     <= d_reg[DW-1] ? (~d_reg + DW'(1)) : d_reg;
            q_reg      <= {1'b0, ad_reg} - {{(QW-REG_W){1'b0}}, cube_size};
            hh_reg     <= hi * hi;
            hl_reg     <= hi * lo;
            ll_reg     <= lo * lo;
            q4_reg     <= q_reg;
            flags4_reg <= '{over: over, pos: pos};
            square_reg <= (SQW'(hh_reg) << (2 * H)) + (SQW'(hl_reg) << (H + 1))
                          + SQW'(ll_reg);
            q5_reg     <= q4_reg;
            flags5_reg <= flags4_reg;
        end
    end

    assign square = square_reg;
    assign offset = q5_reg;
    assign flags  = flags5_reg;

endmodule

>>> rtl/bsd_sqrt.sv
// ----------------------------------------------------------------------------
// bsd_sqrt: pipelined integer square root
// Restoring digit-by-digit root, one result bit per register stage, with
// valid bits and a side vector carried alongside each beat.
// ----------------------------------------------------------------------------
module bsd_sqrt #(
    parameter int ROOT_WIDTH = 33,
    parameter int SIDE_WIDTH = 34
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic                      in_valid,
    input  logic [2*ROOT_WIDTH-1:0]   radicand,
    input  logic [SIDE_WIDTH-1:0]     in_side,
    output logic                      out_valid,
    output logic [ROOT_WIDTH-1:0]     root,
    output logic [SIDE_WIDTH-1:0]     out_side
);

    localparam int RW = ROOT_WIDTH;
    localparam int SW = 2 * ROOT_WIDTH;

    logic [RW-1:0]          valid_reg;
    logic [RW:0]            rem_reg  [RW-1];
    logic [SW-1:0]          rad_reg  [RW-1];
    logic [RW-1:0]          root_reg [RW];
    logic [SIDE_WIDTH-1:0]  side_reg [RW];

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        logic [RW:0]            rem_src;
        logic [SW-1:0]          rad_src;
        logic [RW-1:0]          root_src;
        logic [SIDE_WIDTH-1:0]  side_src;
        logic                   valid_src;
        logic [RW+2:0]          rem_shift;
        logic [RW+2:0]          trial;
        logic [RW+2:0]          diff;
        logic                   ge;

        if (k == 0)
        begin : g_first
            assign rem_src   = '0;
            assign rad_src   = radicand;
            assign root_src  = '0;
            assign side_src  = in_side;
            assign valid_src = in_valid;
        end
        else
        begin : g_next
            assign rem_src   = rem_reg[k-1];
            assign rad_src   = rad_reg[k-1];
            assign root_src  = root_reg[k-1];
            assign side_src  = side_reg[k-1];
            assign valid_src = valid_reg[k-1];
        end

        always_comb
        begin
            rem_shift = {rem_src, rad_src[SW-1:SW-2]};
            trial     = {1'b0, root_src, 2'b01};
            diff      = rem_shift - trial;
            ge        = rem_shift >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[k] <= valid_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                root_reg[k] <= {root_src[RW-2:0], ge};
                side_reg[k] <= side_src;
            end
        end

        if (k < RW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    rem_reg[k] <= ge ? diff[RW:0] : rem_shift[RW:0];
                    rad_reg[k] <= {rad_src[SW-3:0], 2'b00};
                end
            end
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

>>> rtl/bsd_out.sv
// ----------------------------------------------------------------------------
// bsd_out: rounding, saturation and output skid
// Rounds the root to the nearest LSB, picks the saturated, outside or inside
// value, and holds the result beat in an output register with a skid entry.
// ----------------------------------------------------------------------------
module bsd_out #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pipe_valid,
    output logic                           pipe_ready,
    input  logic [COORD_WIDTH:0]           root,
    input  bsd_pkg::bsd_flags_t            flags,
    input  logic [COORD_WIDTH-1:0]         inside_value,
    output logic                           distance_valid,
    input  logic                           distance_ready,
    output logic signed [COORD_WIDTH-1:0]  signed_distance
);

    localparam int W = COORD_WIDTH;
    localparam logic [W-1:0] OUT_MAX = {1'b0, {(W-1){1'b1}}};

    logic [W+1:0]  rounded;
    logic [W:0]    half;
    logic [W-1:0]  value;
    logic          take;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [W-1:0]  out_data_reg;
    logic [W-1:0]  out_data_next;
    logic          skid_valid_reg;
    logic          skid_valid_next;
    logic [W-1:0]  skid_data_reg;
    logic [W-1:0]  skid_data_next;

    always_comb
    begin
        rounded = {1'b0, root} + (W+2)'(1);
        half    = rounded[W+1:1];
        if (flags.sat)
        begin
            value = OUT_MAX;
        end
        else if (flags.any_pos)
        begin
            value = (half[W:W-1] != 2'b00) ? OUT_MAX : half[W-1:0];
        end
        else
        begin
            value = inside_value;
        end
    end

    assign pipe_ready = !skid_valid_reg;
    assign take       = pipe_valid && !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || distance_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = take;
                if (take)
                begin
                    out_data_next = value;
                end
            end
        end
        else if (take)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign distance_valid  = out_valid_reg;
    assign signed_distance = out_data_reg;

endmodule

>>> rtl/box_signed_distance.sv
// ----------------------------------------------------------------------------
// box_signed_distance: signed distance from a point to an axis-aligned cube
// From point beat to distance beat the path runs through seven offset and
// square stages, one stage per root bit, and the output register. Throughput
// is one beat per cycle while the skid entry is empty. Reset empties the
// pipeline and restores the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module box_signed_distance #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_enable,
    input  logic [bsd_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [bsd_pkg::REG_WIDTH-1:0]         cfg_data,
    input  logic                                  point_valid,
    output logic                                  point_ready,
    input  logic signed [COORD_WIDTH-1:0]         point_x,
    input  logic signed [COORD_WIDTH-1:0]         point_y,
    input  logic signed [COORD_WIDTH-1:0]         point_z,
    output logic                                  distance_valid,
    input  logic                                  distance_ready,
    output logic signed [COORD_WIDTH-1:0]         signed_distance
);

    localparam int W       = COORD_WIDTH;
    localparam int REG_W   = bsd_pkg::REG_WIDTH;
    localparam int DW      = ((W + 1 > REG_W + 1) ? W + 1 : REG_W + 1) + 1;
    localparam int QW      = DW + 1;
    localparam int SQW     = 2 * W;
    localparam int RW      = W + 1;
    localparam int SW      = 2 * RW;
    localparam int FLAGS_W = $bits(bsd_pkg::bsd_flags_t);
    localparam int SIDE_W  = W + FLAGS_W;
    localparam logic [QW-1:0] HALF_LIMIT = QW'(1) << (W - 1);
    localparam logic [W-1:0]  OUT_MIN    = {1'b1, {(W-1){1'b0}}};

    logic [REG_W-1:0]          scene_x_reg;
    logic [REG_W-1:0]          scene_y_reg;
    logic [REG_W-1:0]          scene_z_reg;
    logic [REG_W-1:0]          cube_reg;

    logic                      advance;
    logic [6:0]                front_valid_reg;

    logic [SQW-1:0]            sq_x;
    logic [SQW-1:0]            sq_y;
    logic [SQW-1:0]            sq_z;
    logic signed [QW-1:0]      q_x;
    logic signed [QW-1:0]      q_y;
    logic signed [QW-1:0]      q_z;
    bsd_pkg::bsd_axis_flags_t  fl_x;
    bsd_pkg::bsd_axis_flags_t  fl_y;
    bsd_pkg::bsd_axis_flags_t  fl_z;

    logic signed [QW-1:0]      max_xy;
    logic signed [QW-1:0]      max_q;
    logic [SW-1:0]             sum_xy6_reg;
    logic [SQW-1:0]            sq_z6_reg;
    logic signed [QW-1:0]      max_q6_reg;
    bsd_pkg::bsd_flags_t       flags6_reg;
    logic [SW-1:0]             sum7_reg;
    logic [W-1:0]              inside7_reg;
    bsd_pkg::bsd_flags_t       flags7_reg;

    logic [QW-1:0]             neg_max;
    logic [QW-1:0]             half_k;
    logic [QW-1:0]             neg_half;
    logic [W-1:0]              inside_next;

    logic                      sqrt_valid;
    logic [RW-1:0]             sqrt_root;
    logic [SIDE_W-1:0]         sqrt_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scene_x_reg <= bsd_pkg::SCENE_SIZE_RESET;
            scene_y_reg <= bsd_pkg::SCENE_SIZE_RESET;
            scene_z_reg <= bsd_pkg::SCENE_SIZE_RESET;
            cube_reg    <= bsd_pkg::CUBE_SIZE_RESET;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                bsd_pkg::REG_SCENE_SIZE_X: scene_x_reg <= cfg_data;
                bsd_pkg::REG_SCENE_SIZE_Y: scene_y_reg <= cfg_data;
                bsd_pkg::REG_SCENE_SIZE_Z: scene_z_reg <= cfg_data;
                bsd_pkg::REG_CUBE_SIZE:    cube_reg    <= cfg_data;
                default:                   ;
            endcase
        end
    end

    assign point_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= '0;
        end
        else if (advance)
        begin
            front_valid_reg <= {front_valid_reg[5:0], point_valid};
        end
    end

    bsd_axis #(.COORD_WIDTH(W)) u_axis_x (
        .clk        (clk),
        .advance    (advance),
        .point      (point_x),
        .scene_size (scene_x_reg),
        .cube_size  (cube_reg),
        .square     (sq_x),
        .offset     (q_x),
        .flags      (fl_x)
    );

    bsd_axis #(.COORD_WIDTH(W)) u_axis_y (
        .clk        (clk),
        .advance    (advance),
        .point      (point_y),
        .scene_size (scene_y_reg),
        .cube_size  (cube_reg),
        .square     (sq_y),
        .offset     (q_y),
        .flags      (fl_y)
    );

    bsd_axis #(.COORD_WIDTH(W)) u_axis_z (
        .clk        (clk),
        .advance    (advance),
        .point      (point_z),
        .scene_size (scene_z_reg),
        .cube_size  (cube_reg),
        .square     (sq_z),
        .offset     (q_z),
        .flags      (fl_z)
    );

    always_comb
    begin
        max_xy = (q_x > q_y) ? q_x : q_y;
        max_q  = (max_xy > q_z) ? max_xy : q_z;
    end

    // Inside the cube the distance is half the largest offset, truncated
    // toward zero in magnitude.
    always_comb
    begin
        neg_max     = -max_q6_reg;
        half_k      = {1'b0, neg_max[QW-1:1]};
        neg_half    = -half_k;
        inside_next = (half_k > HALF_LIMIT) ? OUT_MIN : neg_half[W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_xy6_reg        <= SW'(sq_x) + SW'(sq_y);
            sq_z6_reg          <= sq_z;
            max_q6_reg         <= max_q;
            flags6_reg.sat     <= fl_x.over || fl_y.over || fl_z.over;
            flags6_reg.any_pos <= fl_x.pos || fl_y.pos || fl_z.pos;
            sum7_reg           <= sum_xy6_reg + SW'(sq_z6_reg);
            inside7_reg        <= inside_next;
            flags7_reg         <= flags6_reg;
        end
    end

    bsd_sqrt #(
        .ROOT_WIDTH (RW),
        .SIDE_WIDTH (SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (front_valid_reg[6]),
        .radicand  (sum7_reg),
        .in_side   ({inside7_reg, flags7_reg}),
        .out_valid (sqrt_valid),
        .root      (sqrt_root),
        .out_side  (sqrt_side)
    );

    bsd_out #(.COORD_WIDTH(W)) u_out (
        .clk             (clk),
        .rst_n           (rst_n),
        .pipe_valid      (sqrt_valid),
        .pipe_ready      (advance),
        .root            (sqrt_root),
        .flags           (bsd_pkg::bsd_flags_t'(sqrt_side[FLAGS_W-1:0])),
        .inside_value    (sqrt_side[SIDE_W-1:FLAGS_W]),
        .distance_valid  (distance_valid),
        .distance_ready  (distance_ready),
        .signed_distance (signed_distance)
    );

endmodule

>>> tb/sv/tb_box_signed_distance.sv
// ----------------------------------------------------------------------------
// tb_box_signed_distance: self-checking testbench for box_signed_distance
// A queue-fed driver offers query points in bursts with random gaps, and a
// monitor checks every distance beat against an exact fixed-point predictor.
// The run steps through several cube and scene settings, extremes included.
// ----------------------------------------------------------------------------
module tb_box_signed_distance;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     REG_WIDTH       = bsd_pkg::REG_WIDTH;
    localparam int     CFG_INDEX_WIDTH = bsd_pkg::CFG_INDEX_WIDTH;
    localparam int     LIMIT_CYCLES    = 400000;
    localparam longint FAR_OFFSET      = 64'sd4294967296;

    localparam logic [CFG_INDEX_WIDTH-1:0] UNUSED_REG_INDEX = 3'd6;

    localparam logic signed [31:0] COORD_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] COORD_MIN = 32'sh80000000;
    localparam logic signed [31:0] MID       = 32'sd2097152;
    localparam logic signed [31:0] ONE       = 32'sd65536;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } point_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_write_enable = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0]    cfg_index = '0;
    logic [REG_WIDTH-1:0]          cfg_data = '0;
    logic                          point_valid = 1'b0;
    logic                          point_ready;
    logic signed [31:0]            point_x = '0;
    logic signed [31:0]            point_y = '0;
    logic signed [31:0]            point_z = '0;
    logic                          distance_valid;
    logic                          distance_ready = 1'b0;
    logic signed [31:0]            signed_distance;

    logic [REG_WIDTH-1:0]          scene_size [3];
    logic [REG_WIDTH-1:0]          cube_edge;

    point_t                        point_queue [$];
    logic signed [31:0]            distance_queue [$];

    bit                            point_taken;
    int                            burst_left;
    int                            gap_left;
    point_t                        next_point;
    bit                            send_point;

    int                            results_seen;
    int                            error_count;
    int                            cycle_count;

    int                            hold_left;
    bit                            long_hold_done;
    int                            stall_mode;
    int                            stall_phase;
    int                            rx_cycle;
    bit                            ready_next;

    box_signed_distance i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .point_valid      (point_valid),
        .point_ready      (point_ready),
        .point_x          (point_x),
        .point_y          (point_y),
        .point_z          (point_z),
        .distance_valid   (distance_valid),
        .distance_ready   (distance_ready),
        .signed_distance  (signed_distance)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned floor_sqrt(input bit [127:0] s);
        bit [63:0]  root;
        bit [63:0]  trial;
        bit [127:0] trial_sq;
        int         b;
        root = '0;
        for (b = 49; b >= 0; b--)
        begin
            trial    = root | (64'd1 << b);
            trial_sq = {64'd0, trial} * {64'd0, trial};
            if (trial_sq <= s)
                root = trial;
        end
        return root;
    endfunction

    function automatic logic signed [31:0] box_distance(input logic signed [31:0] px,
                                                       input logic signed [31:0] py,
                                                       input logic signed [31:0] pz);
        logic signed [31:0] p [3];
        longint             d;
        longint             ad;
        longint             q2;
        longint             max_q;
        longint             k;
        bit [127:0]         sq;
        bit [127:0]         sum;
        bit                 any_pos;
        bit                 far_out;
        longint unsigned    root;
        longint unsigned    rounded;
        p[0]    = px;
        p[1]    = py;
        p[2]    = pz;
        sum     = '0;
        any_pos = 1'b0;
        far_out = 1'b0;
        max_q   = 0;
        for (int a = 0; a < 3; a++)
        begin
            // Offsets are held at twice the scale so that half a step is exact.
            d  = 2 * longint'(p[a]) - longint'(scene_size[a]);
            ad = (d < 0) ? -d : d;
            q2 = ad - longint'(cube_edge);
            if (a == 0 || q2 > max_q)
                max_q = q2;
            if (q2 > 0)
            begin
                any_pos = 1'b1;
                if (q2 >= FAR_OFFSET)
                    far_out = 1'b1;
                else
                begin
                    sq  = 128'(q2);
                    sum = sum + sq * sq;
                end
            end
        end
        if (far_out)
            return COORD_MAX;
        if (any_pos)
        begin
            root    = floor_sqrt(sum);
            rounded = (root + 1) >> 1;
            if (rounded > 64'h7FFFFFFF)
                return COORD_MAX;
            return rounded[31:0];
        end
        k = -max_q;
        k = -(k >>> 1);
        if (k < -64'sd2147483648)
            return COORD_MIN;
        return k[31:0];
    endfunction

    function automatic logic signed [31:0] random_coord(input int axis);
        longint centre;
        longint half;
        longint offset;
        centre = longint'(scene_size[axis]) / 2;
        half   = longint'(cube_edge) / 2;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: offset = half + longint'($urandom_range(0, 64)) - 32;
            2: offset = longint'($urandom_range(0, half[31:0]));
            3: offset = longint'($urandom_range(0, half[31:0])) * 3;
            4:
            begin
                case ($urandom_range(0, 4))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return 32'sd0;
                    3: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            default: offset = longint'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 1))
            offset = -offset;
        return 32'(centre + offset);
    endfunction

    task automatic add_point(input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] z);
        point_t pt;
        pt.x = x;
        pt.y = y;
        pt.z = z;
        point_queue.push_back(pt);
    endtask

    task automatic add_random_points(input int count);
        for (int i = 0; i < count; i++)
            add_point(random_coord(0), random_coord(1), random_coord(2));
    endtask

    task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] index,
                                  input logic [REG_WIDTH-1:0] value);
        @(negedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index        <= index;
        cfg_data         <= value;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        case (index)
            bsd_pkg::REG_SCENE_SIZE_X: scene_size[0] = value;
            bsd_pkg::REG_SCENE_SIZE_Y: scene_size[1] = value;
            bsd_pkg::REG_SCENE_SIZE_Z: scene_size[2] = value;
            bsd_pkg::REG_CUBE_SIZE:    cube_edge     = value;
            default:                   ;
        endcase
    endtask

    task automatic write_all(input logic [REG_WIDTH-1:0] sx, input logic [REG_WIDTH-1:0] sy,
                             input logic [REG_WIDTH-1:0] sz, input logic [REG_WIDTH-1:0] edge_len);
        write_register(bsd_pkg::REG_SCENE_SIZE_X, sx);
        write_register(bsd_pkg::REG_SCENE_SIZE_Y, sy);
        write_register(bsd_pkg::REG_SCENE_SIZE_Z, sz);
        write_register(bsd_pkg::REG_CUBE_SIZE, edge_len);
    endtask

    task automatic wait_idle();
        while (point_queue.size() != 0 || point_valid || distance_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Driver: beats are offered at the falling edge, in bursts with gaps.
    always @(negedge clk)
    begin
        if (rst_n && (!point_valid || point_taken))
        begin
            send_point = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (point_queue.size() != 0)
            begin
                next_point = point_queue.pop_front();
                send_point = 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            if (send_point)
            begin
                point_x     <= next_point.x;
                point_y     <= next_point.y;
                point_z     <= next_point.z;
                point_valid <= 1'b1;
            end
            else
                point_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        point_taken = rst_n && point_valid && point_ready;
        if (point_taken)
            distance_queue.push_back(box_distance(point_x, point_y, point_z));
    end

    // Receiver: its own stall pattern, plus one long hold-off to fill the block.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rx_cycle++;
            if (!long_hold_done && results_seen >= 400)
            begin
                hold_left      = 300;
                long_hold_done = 1'b1;
            end
            if (stall_phase == 0)
            begin
                stall_mode  = $urandom_range(0, 3);
                stall_phase = $urandom_range(16, 96);
            end
            else
                stall_phase--;
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0:       ready_next = 1'b1;
                    1:       ready_next = ($urandom_range(0, 3) != 0);
                    2:       ready_next = ($urandom_range(0, 3) == 0);
                    default: ready_next = ((rx_cycle % 5) < 3);
                endcase
            end
            distance_ready <= ready_next;
        end
    end

    // Monitor: each distance beat is checked against the oldest prediction.
    always @(posedge clk)
    begin
        logic signed [31:0] expected;
        if (rst_n && distance_valid && distance_ready)
        begin
            results_seen++;
            if (distance_queue.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: distance beat with no point pending, got %0d (0x%08h)",
                             $realtime, signed_distance, signed_distance);
            end
            else
            begin
                expected = distance_queue.pop_front();
                if (signed_distance !== expected)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: distance wrong, expected %0d (0x%08h), got %0d (0x%08h)",
                                 $realtime, expected, expected, signed_distance,
                                 signed_distance);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        scene_size[0] = bsd_pkg::SCENE_SIZE_RESET;
        scene_size[1] = bsd_pkg::SCENE_SIZE_RESET;
        scene_size[2] = bsd_pkg::SCENE_SIZE_RESET;
        cube_edge     = bsd_pkg::CUBE_SIZE_RESET;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: cube of edge 32.0 centred at 32.0 on every axis.
        add_point(MID, MID, MID);
        add_point(MID + 16 * ONE, MID, MID);
        add_point(MID + 16 * ONE + 1, MID, MID);
        add_point(MID + 16 * ONE - 1, MID, MID);
        add_point(MID + 28 * ONE, MID, MID);
        add_point(MID - 28 * ONE, MID, MID);
        add_point(MID, MID + 5 * ONE, MID - 7 * ONE);
        add_point(50 * ONE, 50 * ONE, 50 * ONE);
        add_point(MID + 16 * ONE + 1, MID - 16 * ONE - 1, MID + 16 * ONE + 1);
        add_point(COORD_MIN, COORD_MIN, COORD_MIN);
        add_point(COORD_MAX, COORD_MAX, COORD_MAX);
        add_point(32'sd0, 32'sd0, 32'sd0);
        add_point(-32'sd1, -32'sd1, -32'sd1);
        add_point(COORD_MAX, MID, MID);
        add_point(COORD_MIN, MID, MID);
        add_point(MID, COORD_MIN, COORD_MAX);
        add_point(-32'sd2146435071, -32'sd2146435071, -32'sd2146435071);
        add_point(-32'sd2146435071, MID, MID);
        add_point(32'sh55555555, 32'shAAAAAAAA, 32'sh0F0F0F0F);
        add_point(32'sd1, 32'sd0, -32'sd1);
        add_random_points(150);
        wait_idle();

        write_all('0, '0, '0, '0);
        add_random_points(150);
        wait_idle();

        write_all('1, '1, '1, '1);
        add_random_points(150);
        wait_idle();

        write_all(REG_WIDTH'($urandom), REG_WIDTH'($urandom), REG_WIDTH'($urandom), '0);
        add_random_points(150);
        wait_idle();

        write_all(31'd131073, 31'd3, 31'd0, '1);
        add_random_points(150);
        wait_idle();

        write_all(REG_WIDTH'($urandom_range(0, 1 << 24)),
                  REG_WIDTH'($urandom_range(0, 1 << 24)),
                  REG_WIDTH'($urandom_range(0, 1 << 24)),
                  REG_WIDTH'($urandom_range(0, 1 << 23)));
        add_random_points(150);
        wait_idle();

        write_all(REG_WIDTH'($urandom), REG_WIDTH'($urandom), REG_WIDTH'($urandom),
                  REG_WIDTH'($urandom));
        // A write beyond the register list must leave the settings alone.
        write_register(UNUSED_REG_INDEX, REG_WIDTH'($urandom));
        add_random_points(150);
        wait_idle();

        repeat (60) @(posedge clk);
        if (error_count == 0 && distance_queue.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
